>>> design/sma_pkg.sv
// Shared types and constants for the simple moving average core.
// Used by the front queue, the window sequencer, the divider and the top level.
// No dependencies.
package sma_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_SEED = 1'b1;

   localparam int        WINDOW_SIZE_W     = 7;
   localparam logic [6:0] WINDOW_SIZE_RESET = 7'd8;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic busy;
      logic done;
   } sma_div_status_type;

endpackage

>>> design/sma_front.sv
// Input side of the moving average core: takes request words, decodes the
// operation and holds them in a two-entry queue for the window sequencer.
// Depends on sma_pkg.
module sma_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          item_valid,
   input  logic                          item_ready,
   output logic                          item_seed,
   output logic signed [SAMPLE_BITS-1:0] item_sample
);
   import sma_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [SAMPLE_BITS:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 push, pop;

   assign req_ready  = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign item_valid = (fill_ff != '0);
   assign push       = req_valid & req_ready;
   assign pop        = item_valid & item_ready;

   assign item_seed   = entry_ff[rd_ptr_ff][SAMPLE_BITS];
   assign item_sample = entry_ff[rd_ptr_ff][SAMPLE_BITS-1:0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {(req_operation == OP_SEED), req_sample};
      end
   end

endmodule

>>> design/sma_div.sv
// Bit-serial signed divider: running sum over sample count, truncated
// toward zero, one quotient bit per cycle. Depends on sma_pkg.
module sma_div #(
   parameter int SUM_W       = 30,
   parameter int CNT_W       = 7,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [SUM_W-1:0]              dividend,
   input  logic [CNT_W-1:0]                     divisor,
   output sma_pkg::sma_div_status_type          status,
   output logic signed [SAMPLE_BITS-1:0]        quotient
);
   import sma_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int REM_W  = CNT_W + 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [REM_W-1:0]  trial;
   logic [SUM_W-1:0]  quo_signed;

   assign trial = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_W'(SUM_W);
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quo_signed  = neg_ff ? -quo_ff : quo_ff;
   assign quotient    = quo_signed[SAMPLE_BITS-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> design/sma_back.sv
// Window sequencer of the moving average core: keeps the sample store,
// running sum and count, drops old entries and drives the result register.
// Depends on sma_pkg and sma_div.
module sma_back #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24,
   parameter int CNT_W       = 7,
   parameter int SUM_W       = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [sma_pkg::WINDOW_SIZE_W-1:0]   csr_window_size,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  logic                                item_seed,
   input  logic signed [SAMPLE_BITS-1:0]       item_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_average,
   output logic [CNT_W-1:0]                    rsp_sample_count,
   output logic                                rsp_empty_res
);
   import sma_pkg::*;

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LIM_W = (CNT_W > WINDOW_SIZE_W) ? CNT_W : WINDOW_SIZE_W;
   localparam int POS_W = CNT_W + 1;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DROP_RD  = 3'd1;
   localparam logic [2:0] ST_DROP_SUB = 3'd2;
   localparam logic [2:0] ST_APPEND   = 3'd3;
   localparam logic [2:0] ST_CHECK    = 3'd4;
   localparam logic [2:0] ST_START    = 3'd5;
   localparam logic [2:0] ST_DIVIDE   = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic [WINDOW_SIZE_W-1:0]      wsize_ff, wsize_in;
   logic [IDX_W-1:0]              oldest_ff, oldest_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic                          appended_ff, appended_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_average_ff, rsp_average_in;
   logic [CNT_W-1:0]              rsp_count_ff, rsp_count_in;
   logic                          rsp_empty_ff, rsp_empty_in;

   logic [SAMPLE_BITS-1:0]        store [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0]        rd_data_ff;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [SAMPLE_BITS-1:0]        wr_data;

   logic [LIM_W-1:0]              limit;
   logic [POS_W-1:0]              pos_sum;
   logic [IDX_W-1:0]              pos;
   logic                          div_start;
   sma_div_status_type            div_status;
   logic signed [SAMPLE_BITS-1:0] div_quotient;

   assign limit = (LIM_W'(wsize_ff) > LIM_W'(WINDOW_MAX)) ? LIM_W'(WINDOW_MAX)
                                                          : LIM_W'(wsize_ff);
   assign pos_sum = POS_W'(oldest_ff) + POS_W'(count_ff);
   assign pos = (pos_sum >= POS_W'(WINDOW_MAX)) ?
                IDX_W'(pos_sum - POS_W'(WINDOW_MAX)) : IDX_W'(pos_sum);

   assign item_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      wsize_in       = csr_valid ? csr_window_size : wsize_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      appended_in    = appended_ff;
      sample_in      = sample_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_average_in = rsp_average_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      wr_en          = 1'b0;
      wr_addr        = pos;
      wr_data        = sample_ff;
      div_start      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               sample_in   = item_sample;
               appended_in = 1'b0;
               if (item_seed) begin
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = item_sample;
                  oldest_in = '0;
                  count_in  = CNT_W'(1);
                  sum_in    = SUM_W'(item_sample);
                  state_in  = ST_START;
               end else if (count_ff >= CNT_W'(WINDOW_MAX)) begin
                  state_in = ST_DROP_RD;
               end else begin
                  state_in = ST_APPEND;
               end
            end
         end
         ST_DROP_RD: begin
            state_in = ST_DROP_SUB;
         end
         ST_DROP_SUB: begin
            sum_in    = sum_ff - SUM_W'($signed(rd_data_ff));
            oldest_in = (oldest_ff == IDX_W'(WINDOW_MAX - 1)) ? '0 : oldest_ff + 1'b1;
            count_in  = count_ff - 1'b1;
            state_in  = appended_ff ? ST_CHECK : ST_APPEND;
         end
         ST_APPEND: begin
            wr_en       = 1'b1;
            count_in    = count_ff + 1'b1;
            sum_in      = sum_ff + SUM_W'(sample_ff);
            appended_in = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (LIM_W'(count_ff) > limit) ? ST_DROP_RD : ST_START;
         end
         ST_START: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               avg_in   = div_quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = avg_ff;
               rsp_count_in   = count_ff;
               rsp_empty_in   = (count_ff == '0);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wsize_ff     <= WINDOW_SIZE_RESET;
         oldest_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         appended_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsize_ff     <= wsize_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         appended_ff  <= appended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      avg_ff         <= avg_in;
      rsp_average_ff <= rsp_average_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[oldest_ff];
   end

   sma_div #(
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_empty_res    = rsp_empty_ff;

endmodule

>>> design/simple_moving_average_core.sv
// Top level of the simple moving average core.
// Depends on sma_pkg, sma_front and sma_back.
//
// Request words carry an operation (add a sample, or seed the window with one
// sample) and a signed sample with 8 fraction bits. Each request yields one
// response word: the truncated mean of the window, the number of stored
// samples and an empty flag (mean zero when the window is empty).
// The csr channel writes the window size; it is always ready and should be
// used only while no request is in flight.
// A two-word input queue accepts requests while the window sequencer works.
// The mean is computed by the bit-serial divider, which is skipped when the
// window is empty; every entry dropped from the window, on a full store or
// after the window size shrinks, adds a store read and a sum update.
// Reset empties the window, clears the queue and the response valid flag and
// sets the window size to 8. When the receiver stalls, the response is held
// in its register, the next word is computed behind it, and the queue fills
// before req_ready drops.
module simple_moving_average_core #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_average,
   output logic [$clog2(WINDOW_MAX+1)-1:0]       rsp_sample_count,
   output logic                                  rsp_empty_res,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sma_pkg::WINDOW_SIZE_W-1:0]     csr_window_size
);
   import sma_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

   logic                          item_valid;
   logic                          item_ready;
   logic                          item_seed;
   logic signed [SAMPLE_BITS-1:0] item_sample;

   assign csr_ready = 1'b1;

   sma_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_sample    (req_sample),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item_seed     (item_seed),
      .item_sample   (item_sample)
   );

   sma_back #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_window_size  (csr_window_size),
      .item_valid       (item_valid),
      .item_ready       (item_ready),
      .item_seed        (item_seed),
      .item_sample      (item_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_sample_count (rsp_sample_count),
      .rsp_empty_res    (rsp_empty_res)
   );

endmodule

>>> sim/simple_moving_average_core_tb.sv
// Self-checking testbench for simple_moving_average_core: drives request, response and csr
// channels with random idling and compares every response word against a window-mean tracker.
// Depends on sma_pkg and the simple_moving_average_core RTL.
module simple_moving_average_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sma_pkg::*;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 24;
   localparam int COUNT_W     = $clog2(WINDOW_MAX + 1);
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [6:0] PHASE_SIZES [11] = '{127, 64, 2, 0, 100, 1, 64, 17, 5, 127, 8};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic [COUNT_W-1:0]            sample_count;
      logic                          empty_res;
   } mean_word_type;

   class window_mean_tracker;
      logic signed [SAMPLE_BITS-1:0] samples [WINDOW_MAX];
      int unsigned                   head;
      int unsigned                   filled;
      longint                        total;
      logic [WINDOW_SIZE_W-1:0]      size_reg;
      mean_word_type                 expected_means [$];
      int unsigned                   errors;

      function new();
         head     = 0;
         filled   = 0;
         total    = 0;
         size_reg = WINDOW_SIZE_RESET;
         errors   = 0;
      endfunction

      function void set_window(input logic [WINDOW_SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      function int unsigned pending();
         return expected_means.size();
      endfunction

      function void drop_oldest();
         if (filled != 0) begin
            total  -= longint'(samples[head]);
            head    = (head + 1) % WINDOW_MAX;
            filled -= 1;
         end
      endfunction

      function void accept_sample(input logic op, input logic signed [SAMPLE_BITS-1:0] value);
         int unsigned   limit;
         longint        mean;
         mean_word_type word;
         limit = (size_reg > WINDOW_MAX) ? WINDOW_MAX : size_reg;
         if (op == OP_SEED) begin
            head       = 0;
            samples[0] = value;
            filled     = 1;
            total      = longint'(value);
         end else begin
            if (filled >= WINDOW_MAX) drop_oldest();
            samples[(head + filled) % WINDOW_MAX] = value;
            filled += 1;
            total  += longint'(value);
            while (filled > limit) drop_oldest();
         end
         mean              = (filled != 0) ? total / longint'(filled) : 0;
         word.average      = mean[SAMPLE_BITS-1:0];
         word.sample_count = filled[COUNT_W-1:0];
         word.empty_res    = (filled == 0);
         expected_means.push_back(word);
      endfunction

      function void check_mean(input logic signed [SAMPLE_BITS-1:0] average,
                               input logic [COUNT_W-1:0] sample_count,
                               input logic empty_res);
         mean_word_type word;
         if (expected_means.size() == 0) begin
            $error("unexpected response word: average %0d, sample_count %0d, empty_res %0b",
                   average, sample_count, empty_res);
            errors++;
            return;
         end
         word = expected_means.pop_front();
         if (average !== word.average) begin
            $error("average: expected %0d, actual %0d", word.average, average);
            errors++;
         end
         if (sample_count !== word.sample_count) begin
            $error("sample_count: expected %0d, actual %0d", word.sample_count, sample_count);
            errors++;
         end
         if (empty_res !== word.empty_res) begin
            $error("empty_res: expected %0b, actual %0b", word.empty_res, empty_res);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_operation = OP_ADD;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_average;
   logic [COUNT_W-1:0]            rsp_sample_count;
   logic                          rsp_empty_res;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [WINDOW_SIZE_W-1:0]      csr_window_size = WINDOW_SIZE_RESET;

   window_mean_tracker tracker = new();
   bit                 req_burst = 1'b0;
   bit                 hold_responses = 1'b0;
   int unsigned        quiet_cycles = 0;

   simple_moving_average_core #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average     (rsp_average),
      .rsp_sample_count(rsp_sample_count),
      .rsp_empty_res   (rsp_empty_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   always #5 clock = ~clock;

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      logic signed [SAMPLE_BITS-1:0] value;
      case ($urandom_range(0, 7))
         0: value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1: value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2: value = SAMPLE_BITS'(int'($urandom_range(0, 32)) - 16);
         default: value = SAMPLE_BITS'($urandom());
      endcase
      return value;
   endfunction

   task automatic send_word(input logic op, input logic signed [SAMPLE_BITS-1:0] value);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample    <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.accept_sample(op, value);
   endtask

   task automatic write_window_size(input logic [WINDOW_SIZE_W-1:0] value);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.set_window(value);
      csr_valid <= 1'b0;
   endtask

   initial begin : response_side
      int unsigned gap;
      bit          rsp_burst;
      rsp_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = ~rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, 19);
         if (hold_responses) begin
            hold_responses = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_mean(rsp_average, rsp_sample_count, rsp_empty_res);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [WINDOW_SIZE_W-1:0] size;
      int unsigned              count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default window of eight: extremes, truncation toward zero, seed, overflow drops.
      send_word(OP_ADD, 24'sd0);
      send_word(OP_ADD, 24'sh7FFFFF);
      send_word(OP_ADD, 24'sh800000);
      send_word(OP_ADD, -24'sd1);
      send_word(OP_ADD, -24'sd2);
      send_word(OP_SEED, -24'sd5);
      send_word(OP_ADD, 24'sd2);
      repeat (7) send_word(OP_ADD, 24'sh7FFFFF);

      // A zero window empties on every sample, while a seed keeps one entry.
      write_window_size(7'd0);
      send_word(OP_ADD, 24'sd100);
      send_word(OP_SEED, 24'sh800000);
      send_word(OP_ADD, 24'sd5);

      write_window_size(7'd1);
      send_word(OP_ADD, 24'sh7FFFFF);
      send_word(OP_ADD, 24'sh800000);

      write_window_size(7'd127);
      send_word(OP_SEED, 24'sd3);
      send_word(OP_ADD, -24'sd7);

      for (int p = 0; p < 12; p++) begin
         size = (p < 11) ? PHASE_SIZES[p] : WINDOW_SIZE_W'($urandom_range(0, 127));
         write_window_size(size);
         req_burst = ($urandom_range(0, 2) == 0);
         if (p == 2) begin
            req_burst      = 1'b1;
            hold_responses = 1'b1;
         end
         count = (size >= 40) ? $urandom_range(90, 150) : $urandom_range(40, 90);
         repeat (count) send_word(($urandom_range(0, 11) == 0) ? OP_SEED : OP_ADD, pick_sample());
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
design/sma_pkg.sv
design/sma_front.sv
design/sma_div.sv
design/sma_back.sv
design/simple_moving_average_core.sv
sim/simple_moving_average_core_tb.sv
